// ===== rtl/tlgs_pkg.sv =====
`default_nettype none

package tlgs_pkg;

	// Leaf mode codes, as they appear on the result channel.
	typedef enum logic [2:0] {
		MODE_CLOSED     = 3'd0,
		MODE_WAIT_OPEN  = 3'd1,
		MODE_OPENING    = 3'd2,
		MODE_OPENED     = 3'd3,
		MODE_WAIT_CLOSE = 3'd4,
		MODE_CLOSING    = 3'd5
	} mode_t;

	// Configuration register indexes.
	localparam int unsigned CFG_ADDR_BITS = 3;
	localparam int unsigned CFG_DATA_BITS = 16;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		CFG_OPEN_WAIT_LEAF1  = 3'd0,
		CFG_OPEN_WAIT_LEAF2  = 3'd1,
		CFG_CLOSE_WAIT_LEAF1 = 3'd2,
		CFG_CLOSE_WAIT_LEAF2 = 3'd3,
		CFG_TRAVEL_LIMIT     = 3'd4,
		CFG_CLOSE_OFFSET     = 3'd5
	} cfg_idx_t;

	localparam logic [15:0] OPEN_WAIT_LEAF1_RST  = 16'd2000;
	localparam logic [15:0] OPEN_WAIT_LEAF2_RST  = 16'd4000;
	localparam logic [15:0] CLOSE_WAIT_LEAF1_RST = 16'd2000;
	localparam logic [15:0] CLOSE_WAIT_LEAF2_RST = 16'd4000;
	localparam logic [13:0] TRAVEL_LIMIT_RST     = 14'd0;
	localparam logic [13:0] CLOSE_OFFSET_RST     = 14'd0;

	typedef struct packed {
		logic start_press;
		logic open_limit_leaf1;
		logic open_limit_leaf2;
		logic close_limit_leaf1;
		logic close_limit_leaf2;
	} tick_t;

	typedef struct packed {
		logic [2:0] leaf1_state;
		logic [2:0] leaf2_state;
	} gate_t;

	// Timing thresholds seen by one leaf.
	typedef struct packed {
		logic [15:0] open_wait;
		logic [16:0] close_wait;
		logic [13:0] travel_limit;
	} thr_t;

	// Per-tick control handed to one leaf.
	typedef struct packed {
		logic advance;
		logic go_open;
		logic go_close;
		logic open_hit;
		logic close_hit;
	} leaf_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/tlgs_cfg.sv =====
`default_nettype none

module tlgs_cfg
	import tlgs_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
	output thr_t                          thr_leaf1,
	output thr_t                          thr_leaf2
);

	logic [15:0] open_wait1_q;
	logic [15:0] open_wait2_q;
	logic [15:0] close_wait1_q;
	logic [15:0] close_wait2_q;
	logic [13:0] travel_q;
	logic [13:0] offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_wait1_q  <= OPEN_WAIT_LEAF1_RST;
			open_wait2_q  <= OPEN_WAIT_LEAF2_RST;
			close_wait1_q <= CLOSE_WAIT_LEAF1_RST;
			close_wait2_q <= CLOSE_WAIT_LEAF2_RST;
			travel_q      <= TRAVEL_LIMIT_RST;
			offset_q      <= CLOSE_OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_OPEN_WAIT_LEAF1:  open_wait1_q  <= cfg_wdata;
				CFG_OPEN_WAIT_LEAF2:  open_wait2_q  <= cfg_wdata;
				CFG_CLOSE_WAIT_LEAF1: close_wait1_q <= cfg_wdata;
				CFG_CLOSE_WAIT_LEAF2: close_wait2_q <= cfg_wdata;
				CFG_TRAVEL_LIMIT:     travel_q      <= cfg_wdata[13:0];
				CFG_CLOSE_OFFSET:     offset_q      <= cfg_wdata[13:0];
				default: ;
			endcase
		end
	end

	// Leaf 2 closes later by the offset; the sum needs one extra bit.
	always_comb begin
		thr_leaf1.open_wait    = open_wait1_q;
		thr_leaf1.close_wait   = {1'b0, close_wait1_q};
		thr_leaf1.travel_limit = travel_q;
		thr_leaf2.open_wait    = open_wait2_q;
		thr_leaf2.close_wait   = {1'b0, close_wait2_q} + {3'b000, offset_q};
		thr_leaf2.travel_limit = travel_q;
	end

endmodule

`default_nettype wire

// ===== rtl/tlgs_leaf.sv =====
`default_nettype none

module tlgs_leaf
	import tlgs_pkg::*;
#(
	parameter int unsigned ELAPSED_BITS = 17
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire leaf_ctl_t ctl,
	input  wire thr_t      thr,
	output mode_t          mode
);

	mode_t                   mode_q;
	logic [ELAPSED_BITS-1:0] elapsed_q;

	mode_t                   mode_a;
	logic [ELAPSED_BITS-1:0] t_a;
	mode_t                   mode_d;
	logic [ELAPSED_BITS-1:0] elapsed_d;

	always_comb begin
		// Saturating tick count, then the start press can restart the leaf.
		if (elapsed_q == {ELAPSED_BITS{1'b1}}) begin
			t_a = elapsed_q;
		end else begin
			t_a = elapsed_q + ELAPSED_BITS'(1);
		end
		mode_a = mode_q;
		if (ctl.go_open) begin
			mode_a = MODE_WAIT_OPEN;
			t_a    = '0;
		end else if (ctl.go_close) begin
			mode_a = MODE_WAIT_CLOSE;
			t_a    = '0;
		end

		mode_d    = mode_a;
		elapsed_d = t_a;
		case (mode_a)
			MODE_CLOSED, MODE_OPENED: ;
			MODE_WAIT_OPEN: begin
				if (t_a > ELAPSED_BITS'(thr.open_wait)) begin
					mode_d    = MODE_OPENING;
					elapsed_d = '0;
				end
			end
			MODE_OPENING: begin
				if (t_a > ELAPSED_BITS'(thr.travel_limit) || ctl.open_hit) begin
					mode_d    = MODE_OPENED;
					elapsed_d = '0;
				end
			end
			MODE_WAIT_CLOSE: begin
				if (t_a > ELAPSED_BITS'(thr.close_wait)) begin
					mode_d    = MODE_CLOSING;
					elapsed_d = '0;
				end
			end
			MODE_CLOSING: begin
				if (t_a > ELAPSED_BITS'(thr.travel_limit) || ctl.close_hit) begin
					mode_d    = MODE_CLOSED;
					elapsed_d = '0;
				end
			end
			default: begin
				mode_d    = MODE_CLOSED;
				elapsed_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_CLOSED;
			elapsed_q <= '0;
		end else if (ctl.advance) begin
			mode_q    <= mode_d;
			elapsed_q <= elapsed_d;
		end
	end

	assign mode = mode_q;

endmodule

`default_nettype wire

// ===== rtl/two_leaf_gate_sequencer_unit.sv =====
// Channel  | Direction | Handshake                | Payload
// tick     | in        | tick_valid / tick_ready  | tick_t: start press, four limit events
// gate     | out       | gate_valid / gate_ready  | gate_t: both leaf modes after the tick
// cfg      | in        | cfg_we                   | cfg_addr, cfg_wdata
//
// One tick transfer per cycle is sustained while the output is not stalled. A tick's
// result passes through the input register, then the leaf state registers, which
// double as the result register.
// Reset puts both leaves in closed with cleared counters and loads the
// default delays.
// A stalled output holds the leaf state, and the input register keeps
// accepting until it too is full.
`default_nettype none

module two_leaf_gate_sequencer_unit
	import tlgs_pkg::*;
#(
	parameter int unsigned ELAPSED_BITS = 17
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     tick_valid,
	output logic                          tick_ready,
	input  wire tick_t                    tick,
	output logic                          gate_valid,
	input  wire logic                     gate_ready,
	output gate_t                         gate,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	// Input stage: one tick waits here until the leaves can take it.
	logic      valid_s1;
	tick_t     tick_s1;
	logic      gate_valid_q;
	logic      advance;

	thr_t      thr_leaf1;
	thr_t      thr_leaf2;
	leaf_ctl_t ctl_leaf1;
	leaf_ctl_t ctl_leaf2;
	mode_t     mode_leaf1;
	mode_t     mode_leaf2;
	logic      go_open;
	logic      go_close;

	// The leaf state moves forward only when the result slot is empty or is
	// being drained in this same cycle, so a shown result never changes.
	assign advance    = valid_s1 && (!gate_valid_q || gate_ready);
	assign tick_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_ready && tick_valid) begin
			tick_s1 <= tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_valid_q <= 1'b0;
		end else if (advance) begin
			gate_valid_q <= 1'b1;
		end else if (gate_ready) begin
			gate_valid_q <= 1'b0;
		end
	end

	// A start press acts only when both leaves rest at the same end.
	assign go_open  = tick_s1.start_press
	                  && mode_leaf1 == MODE_CLOSED && mode_leaf2 == MODE_CLOSED;
	assign go_close = tick_s1.start_press
	                  && mode_leaf1 == MODE_OPENED && mode_leaf2 == MODE_OPENED;

	always_comb begin
		ctl_leaf1.advance   = advance;
		ctl_leaf1.go_open   = go_open;
		ctl_leaf1.go_close  = go_close;
		ctl_leaf1.open_hit  = tick_s1.open_limit_leaf1;
		ctl_leaf1.close_hit = tick_s1.close_limit_leaf1;
		ctl_leaf2.advance   = advance;
		ctl_leaf2.go_open   = go_open;
		ctl_leaf2.go_close  = go_close;
		ctl_leaf2.open_hit  = tick_s1.open_limit_leaf2;
		ctl_leaf2.close_hit = tick_s1.close_limit_leaf2;
	end

	tlgs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.thr_leaf1 (thr_leaf1),
		.thr_leaf2 (thr_leaf2)
	);

	tlgs_leaf #(
		.ELAPSED_BITS (ELAPSED_BITS)
	) u_leaf1 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_leaf1),
		.thr    (thr_leaf1),
		.mode   (mode_leaf1)
	);

	tlgs_leaf #(
		.ELAPSED_BITS (ELAPSED_BITS)
	) u_leaf2 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_leaf2),
		.thr    (thr_leaf2),
		.mode   (mode_leaf2)
	);

	// The leaf mode registers hold exactly the state after the last tick.
	assign gate_valid       = gate_valid_q;
	assign gate.leaf1_state = mode_leaf1;
	assign gate.leaf2_state = mode_leaf2;

endmodule

`default_nettype wire

// ===== rtl/tlgs_checker.sv =====
`default_nettype none

module tlgs_checker
	import tlgs_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  tick_valid,
	input wire logic  tick_ready,
	input wire logic  gate_valid,
	input wire logic  gate_ready,
	input wire gate_t gate
);

	// A result that is not taken stays put.
	a_gate_hold: assert property (@(posedge clk) disable iff (!arst_n)
		gate_valid && !gate_ready |=> gate_valid && $stable(gate))
		else $error("gate result changed while stalled");

	// Only defined leaf modes ever leave the block.
	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		gate_valid |-> gate.leaf1_state <= 3'(MODE_CLOSING)
		&& gate.leaf2_state <= 3'(MODE_CLOSING))
		else $error("illegal leaf mode on gate");

	// The input side only stalls behind a full result slot.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_ready |-> gate_valid && !gate_ready)
		else $error("tick stalled without output backpressure");

	// With nothing accepted and nothing shown, a result can still appear from a tick held in the input register.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!gate_valid && !(tick_valid && tick_ready) && tick_ready
		|=> !gate_valid || $past(tick_ready, 1))
		else $error("result appeared without a tick");

endmodule

bind two_leaf_gate_sequencer_unit tlgs_checker u_tlgs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_valid (tick_valid),
	.tick_ready (tick_ready),
	.gate_valid (gate_valid),
	.gate_ready (gate_ready),
	.gate       (gate)
);

`default_nettype wire

// ===== sim/two_leaf_gate_sequencer_unit_test.sv =====
`default_nettype none

// Self-checking bench for the two-leaf gate sequencer.
// Every tick transfer advances a local copy of both leaves, and the leaf modes
// it produces are queued.
// Each gate transfer is compared with the oldest queued pair.
// The run works through several delay settings, from all zero to every
// register at its widest value, and a randomized part with gaps on both channels.
module two_leaf_gate_sequencer_unit_test;
	import tlgs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ELAPSED_BITS = 17;
	localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

	// Register indexes that the block does not decode; writes to them must be dropped.
	localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_HI = 3'd7;

	// Length of the runs that hold a leaf in one mode under a long delay.
	localparam int unsigned HOLD_TICKS = 30;
	localparam int unsigned RANDOM_PHASES = 10;
	localparam int unsigned TICKS_PER_PHASE = 93;
	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int unsigned MAX_PRINTED = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tick_valid = 1'b0;
	logic tick_ready;
	tick_t tick_data = '0;
	logic gate_valid;
	logic gate_ready = 1'b0;
	gate_t gate_data;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	two_leaf_gate_sequencer_unit #(
		.ELAPSED_BITS(ELAPSED_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_ready(tick_ready),
		.tick(tick_data),
		.gate_valid(gate_valid),
		.gate_ready(gate_ready),
		.gate(gate_data),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow copy of the delay registers, loaded with the reset values.
	logic [15:0] open_wait_l1 = OPEN_WAIT_LEAF1_RST;
	logic [15:0] open_wait_l2 = OPEN_WAIT_LEAF2_RST;
	logic [15:0] close_wait_l1 = CLOSE_WAIT_LEAF1_RST;
	logic [15:0] close_wait_l2 = CLOSE_WAIT_LEAF2_RST;
	logic [13:0] travel_max = TRAVEL_LIMIT_RST;
	logic [13:0] close_extra = CLOSE_OFFSET_RST;

	// Predicted leaf state: the mode and the ticks spent in it.
	mode_t leaf_mode [2] = '{MODE_CLOSED, MODE_CLOSED};
	logic [ELAPSED_BITS-1:0] leaf_elapsed [2] = '{'0, '0};

	// Leaf modes still owed by the block, oldest first.
	gate_t pending_gates [$];

	// When this is clear, neither channel inserts gaps.
	bit pacing_on = 1'b0;
	int unsigned tick_count = 0;
	int unsigned result_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_left = 0;

	task automatic flag_error(input string msg);
		if (mismatch_count < MAX_PRINTED) begin
			$display("[%0t] ERROR: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	// Gap length for either channel. Most gaps are zero or short, and a few are long.
	function automatic int unsigned gap_len();
		int unsigned roll;
		if (!pacing_on) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end else if (roll < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic tick_t make_tick(input bit start, input bit open1, input bit open2,
			input bit close1, input bit close2);
		tick_t t;
		t.start_press = start;
		t.open_limit_leaf1 = open1;
		t.open_limit_leaf2 = open2;
		t.close_limit_leaf1 = close1;
		t.close_limit_leaf2 = close2;
		return t;
	endfunction

	// Any mode change restarts the leaf's elapsed count.
	function automatic void move_leaf(input int leaf, input mode_t mode);
		leaf_mode[leaf] = mode;
		leaf_elapsed[leaf] = '0;
	endfunction

	// Advance both leaves by one tick and return the modes the block must report.
	function automatic gate_t advance_gate(input tick_t t);
		logic [1:0] open_hit;
		logic [1:0] close_hit;
		logic [ELAPSED_BITS-1:0] open_limit;
		logic [ELAPSED_BITS-1:0] close_limit;
		gate_t modes;
		int i;
		open_hit = {t.open_limit_leaf2, t.open_limit_leaf1};
		close_hit = {t.close_limit_leaf2, t.close_limit_leaf1};
		for (i = 0; i < 2; i++) begin
			if (leaf_elapsed[i] != ELAPSED_MAX) begin
				leaf_elapsed[i] = leaf_elapsed[i] + ELAPSED_BITS'(1);
			end
		end
		// A press only acts when both leaves rest in the same end position.
		if (t.start_press && leaf_mode[0] == MODE_CLOSED && leaf_mode[1] == MODE_CLOSED) begin
			move_leaf(0, MODE_WAIT_OPEN);
			move_leaf(1, MODE_WAIT_OPEN);
		end
		if (t.start_press && leaf_mode[0] == MODE_OPENED && leaf_mode[1] == MODE_OPENED) begin
			move_leaf(0, MODE_WAIT_CLOSE);
			move_leaf(1, MODE_WAIT_CLOSE);
		end
		for (i = 0; i < 2; i++) begin
			open_limit = {1'b0, (i == 0) ? open_wait_l1 : open_wait_l2};
			// Only leaf 2 carries the extra close delay.
			close_limit = (i == 0) ? {1'b0, close_wait_l1}
				: {1'b0, close_wait_l2} + {3'b000, close_extra};
			case (leaf_mode[i])
				MODE_WAIT_OPEN: begin
					if (leaf_elapsed[i] > open_limit) begin
						move_leaf(i, MODE_OPENING);
					end
				end
				MODE_OPENING: begin
					if (leaf_elapsed[i] > {3'b000, travel_max} || open_hit[i]) begin
						move_leaf(i, MODE_OPENED);
					end
				end
				MODE_WAIT_CLOSE: begin
					if (leaf_elapsed[i] > close_limit) begin
						move_leaf(i, MODE_CLOSING);
					end
				end
				MODE_CLOSING: begin
					if (leaf_elapsed[i] > {3'b000, travel_max} || close_hit[i]) begin
						move_leaf(i, MODE_CLOSED);
					end
				end
				MODE_CLOSED, MODE_OPENED: begin
				end
				default: begin
					move_leaf(i, MODE_CLOSED);
				end
			endcase
		end
		modes.leaf1_state = leaf_mode[0];
		modes.leaf2_state = leaf_mode[1];
		return modes;
	endfunction

	// Offers one tick and returns at the edge of its transfer. Valid stays high into
	// the next call unless that call opens a gap, so valid is assigned only once per edge.
	task automatic send_tick(input tick_t t);
		int unsigned gap;
		gap = gap_len();
		if (gap > 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_valid <= 1'b1;
		tick_data <= t;
		do begin
			@(posedge clk);
		end while (!tick_ready);
		pending_gates.push_back(advance_gate(t));
		tick_count++;
	endtask

	// Each register write pulses the enable with the index and data, then waits with it low.
	task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_OPEN_WAIT_LEAF1: open_wait_l1 = value;
			CFG_OPEN_WAIT_LEAF2: open_wait_l2 = value;
			CFG_CLOSE_WAIT_LEAF1: close_wait_l1 = value;
			CFG_CLOSE_WAIT_LEAF2: close_wait_l2 = value;
			CFG_TRAVEL_LIMIT: travel_max = value[13:0];
			CFG_CLOSE_OFFSET: close_extra = value[13:0];
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic write_all_regs(input logic [15:0] ow1, input logic [15:0] ow2,
			input logic [15:0] cw1, input logic [15:0] cw2,
			input logic [15:0] travel, input logic [15:0] offset);
		write_reg(CFG_OPEN_WAIT_LEAF1, ow1);
		write_reg(CFG_OPEN_WAIT_LEAF2, ow2);
		write_reg(CFG_CLOSE_WAIT_LEAF1, cw1);
		write_reg(CFG_CLOSE_WAIT_LEAF2, cw2);
		write_reg(CFG_TRAVEL_LIMIT, travel);
		write_reg(CFG_CLOSE_OFFSET, offset);
	endtask

	// Stops offering ticks and waits until every queued result has been transferred.
	// The extra edges cover the two-stage path through the block.
	task automatic await_gate_idle();
		tick_valid <= 1'b0;
		while (pending_gates.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Runs empty ticks until both leaves rest in the target position.
	// Start is pressed only from the opposite resting position.
	task automatic cycle_gate_to(input mode_t target);
		mode_t other;
		bit at_rest;
		other = (target == MODE_OPENED) ? MODE_CLOSED : MODE_OPENED;
		while (!(leaf_mode[0] == target && leaf_mode[1] == target)) begin
			at_rest = leaf_mode[0] == other && leaf_mode[1] == other;
			send_tick(make_tick(at_rest, 1'b0, 1'b0, 1'b0, 1'b0));
		end
	endtask

	// A tick with every limit event while the gate is closed must change nothing. With the
	// reset delays a start press then holds both leaves in wait-open over a short run, and
	// short delays finish one full open and close.
	task automatic test_reset_delays();
		pacing_on = 1'b0;
		send_tick(make_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
		send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
		repeat (HOLD_TICKS) send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		await_gate_idle();
		write_all_regs(16'd1, 16'd2, 16'd1, 16'd2, 16'd3, 16'd1);
		cycle_gate_to(MODE_OPENED);
		cycle_gate_to(MODE_CLOSED);
		await_gate_idle();
	endtask

	// The travel limit and the offset are written with their top bits set, so only the low
	// 14 bits may take effect. The writes to the spare indexes must be ignored.
	// The sequence that follows covers these cases:
	//  - a start press while the leaves wait is ignored,
	//  - a limit event outside motion is ignored,
	//  - a limit event for the wrong direction or the other leaf is ignored,
	//  - a start press is ignored while one leaf is still moving.
	task automatic test_directed_sequence();
		pacing_on = 1'b0;
		write_all_regs(16'd0, 16'd2, 16'd1, 16'd0, 16'hC003, 16'hC005);
		write_reg(CFG_SPARE_LO, 16'hFFFF);
		write_reg(CFG_SPARE_HI, 16'h0000);
		send_tick(make_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
		send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
		send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
		send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
		send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
		send_tick(make_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
		send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(make_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
		send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
		send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
		cycle_gate_to(MODE_CLOSED);
		// Press start on every tick, with every limit event present as well.
		repeat (8) send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
		cycle_gate_to(MODE_CLOSED);
		await_gate_idle();
	endtask

	// Every register starts at its widest value, and the 14-bit registers keep only their
	// low 14 bits, all ones. Each wait and each move is held over a short run while its
	// own delay is at the top. The next step comes from lowering that delay or from a
	// limit event.
	task automatic test_widest_delays();
		pacing_on = 1'b0;
		write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
		repeat (HOLD_TICKS) send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		await_gate_idle();
		write_all_regs(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		repeat (HOLD_TICKS) send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(make_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
		send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
		repeat (HOLD_TICKS) send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		await_gate_idle();
		write_all_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0);
		repeat (HOLD_TICKS) send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
		cycle_gate_to(MODE_CLOSED);
		await_gate_idle();
	endtask

	// Short random delays keep full open and close cycles frequent. Most ticks are sparse
	// presses and limit events, and a few are all-ones noise. The first phase has every
	// delay at zero, and one phase in four runs with no gaps.
	task automatic test_random_traffic();
		tick_t t;
		int unsigned phase;
		int unsigned n;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			await_gate_idle();
			if (phase == 0) begin
				write_all_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
			end else begin
				write_all_regs(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
					16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
					{2'($urandom_range(0, 3)), 10'd0, 4'($urandom_range(0, 15))},
					{2'($urandom_range(0, 3)), 11'd0, 3'($urandom_range(0, 6))});
			end
			pacing_on = (phase % 4) != 3;
			for (n = 0; n < TICKS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) < 4) begin
					t = '1;
				end else begin
					t = make_tick($urandom_range(0, 99) < 12, $urandom_range(0, 99) < 8,
						$urandom_range(0, 99) < 8, $urandom_range(0, 99) < 8,
						$urandom_range(0, 99) < 8);
				end
				send_tick(t);
			end
		end
		await_gate_idle();
	endtask

	// The result side stalls with the same gap profile as the sender.
	always @(posedge clk) begin : pace_gate
		int unsigned n;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			gate_ready <= 1'b0;
		end else begin
			n = gap_len();
			if (n > 0) begin
				stall_left <= n - 1;
				gate_ready <= 1'b0;
			end else begin
				gate_ready <= 1'b1;
			end
		end
	end

	// Each gate transfer is checked against the oldest queued pair of modes.
	always @(posedge clk) begin : check_gate
		gate_t want;
		if (arst_n && gate_valid && gate_ready) begin
			if (pending_gates.size() == 0) begin
				flag_error($sformatf("gate transfer with nothing owed: leaf1 %0d leaf2 %0d",
					gate_data.leaf1_state, gate_data.leaf2_state));
			end else begin
				want = pending_gates.pop_front();
				result_count++;
				if (gate_data.leaf1_state !== want.leaf1_state) begin
					flag_error($sformatf("result %0d leaf1_state: got %0d, want %0d",
						result_count, gate_data.leaf1_state, want.leaf1_state));
				end
				if (gate_data.leaf2_state !== want.leaf2_state) begin
					flag_error($sformatf("result %0d leaf2_state: got %0d, want %0d",
						result_count, gate_data.leaf2_state, want.leaf2_state));
				end
			end
		end
	end

	// A hung handshake ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ran past %0d cycles with %0d results still owed",
			CYCLE_LIMIT, pending_gates.size());
		$display("two_leaf_gate_sequencer_unit_test: FAIL");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_delays();
		test_directed_sequence();
		test_widest_delays();
		test_random_traffic();
		repeat (8) @(posedge clk);
		if (pending_gates.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", pending_gates.size()));
		end
		$display("Covered %0d tick transfers and %0d checked results over reset, zero, widest",
			tick_count, result_count);
		$display("and random delay settings, with gaps on both channels.");
		if (mismatch_count == 0) begin
			$display("two_leaf_gate_sequencer_unit_test: PASS");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("two_leaf_gate_sequencer_unit_test: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
